/* rtl/mailbox_semaphore_table_unit_macros.svh */
// assertion macros for the mailbox and semaphore table
`ifndef MAILBOX_SEMAPHORE_TABLE_UNIT_MACROS_SVH
`define MAILBOX_SEMAPHORE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MSEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MSEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msem_pkg.sv */
// shared types and constants for the mailbox and semaphore table
package msem_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 12;
  localparam int WORD_W  = DATA_W + COUNT_W;

  // request opcodes
  localparam logic [2:0] OP_SEND = 3'd0;
  localparam logic [2:0] OP_GET  = 3'd1;
  localparam logic [2:0] OP_INIT = 3'd2;
  localparam logic [2:0] OP_TAKE = 3'd3;
  localparam logic [2:0] OP_GIVE = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNAVAIL = 2'd2;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_ONE = 16'sd1;

  typedef struct packed {
    logic        [2:0]         op;
    logic signed [DATA_W-1:0]  slot_index;
    logic signed [DATA_W-1:0]  write_data;
    logic signed [COUNT_W-1:0] init_count;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] read_data;
  } out_item_t;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_SEND,
    CMD_GET,
    CMD_INIT,
    CMD_TAKE,
    CMD_GIVE,
    CMD_NOP,
    CMD_RANGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic        [SLOT_W-1:0]  slot;
    logic signed [DATA_W-1:0]  write_data;
    logic signed [COUNT_W-1:0] init_count;
  } cmd_t;

endpackage

/* rtl/mailbox_semaphore_table_unit.sv */
// top level of the mailbox and counting semaphore table
//
// Requests enter on the in_ channel (in_valid, in_stall, in_item) and each
// gives exactly one result transaction on the out_ channel (out_valid,
// out_stall, out_item) in request order. A request names a mailbox slot
// (send, get) or a semaphore number offset by SEM_BASE (init, P, V).
// A classifier decodes the opcode and checks ranges, a two-entry queue
// holds classified commands, and an executor does the read-modify-write of
// the slot ram. An item takes a ram read in S_IDLE, then an update and write
// on the single ram port in S_EXEC, and the executor pops no new item until
// it has finished the last one; with everything idle a result shows on
// out_valid after the queue entry, the ram read and the output register.
// After reset the executor sweeps the ram to zero, one slot a cycle, through
// all POOL_DEPTH slots; in_stall is high during the sweep.
// When out_stall holds the output register, the executor waits with its
// current item and the queue keeps taking requests until it holds two.
module mailbox_semaphore_table_unit
  import msem_pkg::*;
#(
  parameter int POOL_DEPTH = 256,
  parameter int SEM_BASE   = 128,
  parameter int SEM_LAST   = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

`include "mailbox_semaphore_table_unit_macros.svh"

  cmd_t       front_cmd;
  cmd_t       q_cmd;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  logic       clearing;
  logic [2:0] inflight_r;
  logic       in_fire;
  logic       out_fire;

  msem_front #(
    .POOL_DEPTH (POOL_DEPTH),
    .SEM_BASE   (SEM_BASE),
    .SEM_LAST   (SEM_LAST)
  ) u_front (
    .item (in_item),
    .cmd  (front_cmd)
  );

  msem_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  msem_back #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // input handshake
  assign in_stall = q_full || clearing;
  assign q_push   = in_valid && !in_stall;
  assign in_fire  = q_push;
  assign out_fire = out_valid && !out_stall;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_fire && !out_fire) begin
      inflight_r <= inflight_r + 3'd1;
    end else if (out_fire && !in_fire) begin
      inflight_r <= inflight_r - 3'd1;
    end
  end

  // checks
  `MSEM_ASSERT_NOW(a_inflight_bound, 1'b1, inflight_r <= 3'd4,
    "more transactions in flight than queue, executor and output can hold")
  `MSEM_ASSERT_NOW(a_no_spurious_out, out_fire, inflight_r != 3'd0,
    "result delivered with no request outstanding")
  `MSEM_ASSERT_NOW(a_clear_quiet, clearing, (inflight_r == 3'd0) && !out_valid,
    "activity during the clearing sweep")
  `MSEM_ASSERT_NEXT(a_drain_empty, (inflight_r == 3'd0) && !in_fire, !out_valid,
    "result shown with nothing outstanding")

endmodule

/* rtl/msem_ram.sv */
// generic single-port ram with registered read
module msem_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/msem_front.sv */
// request classifier: opcode decode and slot range checks
module msem_front
  import msem_pkg::*;
#(
  parameter int POOL_DEPTH = 256,
  parameter int SEM_BASE   = 128,
  parameter int SEM_LAST   = 255
) (
  input  in_item_t item,
  output cmd_t     cmd
);

  // semaphore numbers run from 0 to SEM_SPAN-1
  localparam int SEM_TOP  = (SEM_LAST + 1 < POOL_DEPTH) ? SEM_LAST + 1 : POOL_DEPTH;
  localparam int SEM_SPAN = SEM_TOP - SEM_BASE;

  logic [DATA_W-1:0] mag;
  logic              mbox_ok;
  logic              sem_ok;

  // index checks against the pool and the semaphore window
  assign mag     = {1'b0, item.slot_index[DATA_W-2:0]};
  assign mbox_ok = !item.slot_index[DATA_W-1] && (mag < DATA_W'(POOL_DEPTH));
  assign sem_ok  = (SEM_SPAN > 0) && !item.slot_index[DATA_W-1]
                   && (mag < DATA_W'(SEM_SPAN));

  // opcode decode
  always_comb begin
    cmd.write_data = item.write_data;
    cmd.init_count = item.init_count;
    cmd.slot       = '0;
    cmd.kind       = CMD_NOP;
    unique case (item.op) inside
      OP_SEND, OP_GET: begin
        cmd.slot = item.slot_index[SLOT_W-1:0];
        if (!mbox_ok) begin
          cmd.kind = CMD_RANGE;
        end else if (item.op == OP_SEND) begin
          cmd.kind = CMD_SEND;
        end else begin
          cmd.kind = CMD_GET;
        end
      end
      OP_INIT, OP_TAKE, OP_GIVE: begin
        cmd.slot = item.slot_index[SLOT_W-1:0] + SLOT_W'(SEM_BASE);
        if (!sem_ok) begin
          cmd.kind = CMD_RANGE;
        end else if (item.op == OP_INIT) begin
          cmd.kind = CMD_INIT;
        end else if (item.op == OP_TAKE) begin
          cmd.kind = CMD_TAKE;
        end else begin
          cmd.kind = CMD_GIVE;
        end
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

/* rtl/msem_queue.sv */
// two-entry command queue between the classifier and the executor
module msem_queue
  import msem_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = entry_r[rd_ptr_r];

  // pointer and fill tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/msem_back.sv */
// executor: slot read-modify-write, clearing sweep and output register
module msem_back
  import msem_pkg::*;
#(
  parameter int POOL_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      clearing,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  localparam int ADDR_W = $clog2(POOL_DEPTH);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] clr_addr_r;
  cmd_t              cmd_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [ADDR_W-1:0]                ram_addr;
  logic                             ram_we;
  logic [WORD_W-1:0]                ram_wdata;
  logic [WORD_W-1:0]                ram_rdata;
  logic signed [COUNT_W-1:0]        cur_count;
  logic signed [DATA_W-1:0]         cur_data;
  logic                             exec_we;
  logic [WORD_W-1:0]                exec_word;
  out_item_t                        out_item_nxt;
  logic                             exec_fire;

  msem_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POOL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (q_pop),
    .rdata (ram_rdata)
  );

  assign cur_count = ram_rdata[COUNT_W-1:0];
  assign cur_data  = ram_rdata[WORD_W-1:COUNT_W];

  // slot update for the command held in cmd_r
  always_comb begin
    exec_we      = 1'b0;
    exec_word    = ram_rdata;
    out_item_nxt = '{status: ST_OK, read_data: '0};
    unique case (cmd_r.kind)
      CMD_SEND: begin
        exec_we   = 1'b1;
        exec_word = {cmd_r.write_data, COUNT_ONE};
      end
      CMD_GET: begin
        if (cur_count == '0) begin
          out_item_nxt.status = ST_UNAVAIL;
        end else begin
          exec_we                = 1'b1;
          exec_word              = '0;
          out_item_nxt.read_data = cur_data;
        end
      end
      CMD_INIT: begin
        exec_we   = 1'b1;
        exec_word = {cur_data, cmd_r.init_count};
      end
      CMD_TAKE: begin
        if (cur_count <= 0) begin
          out_item_nxt.status = ST_UNAVAIL;
        end else begin
          exec_we   = 1'b1;
          exec_word = {cur_data, cur_count - COUNT_ONE};
        end
      end
      CMD_GIVE: begin
        if (cur_count != COUNT_MAX) begin
          exec_we   = 1'b1;
          exec_word = {cur_data, cur_count + COUNT_ONE};
        end
      end
      CMD_RANGE: begin
        out_item_nxt.status = ST_RANGE;
      end
      default: begin
        exec_we = 1'b0;
      end
    endcase
  end

  // ram port control
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign ram_we    = (state_r == S_CLEAR) || (exec_fire && exec_we);
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : exec_word;

  always_comb begin
    unique case (state_r)
      S_CLEAR: ram_addr = clr_addr_r;
      S_IDLE:  ram_addr = q_cmd.slot[ADDR_W-1:0];
      S_EXEC:  ram_addr = cmd_r.slot[ADDR_W-1:0];
      default: ram_addr = clr_addr_r;
    endcase
  end

  // state, command latch and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drain the output unless a new result replaces it this cycle
      if (out_valid_r && !out_stall && !exec_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(POOL_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cmd_r   <= q_cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            out_valid_r <= 1'b1;
            out_item_r  <= out_item_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* bench/tb_top.sv */
// testbench for the mailbox and counting semaphore table
module tb_top;
  import msem_pkg::*;

  localparam int POOL_DEPTH  = 256;
  localparam int SEM_BASE    = 128;
  localparam int SEM_LAST    = 255;
  localparam int LONG_HOLD   = 40;
  localparam int SETTLE      = 8;
  localparam int STUCK_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  // opcodes the block treats as no-ops
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic signed [31:0] IDX_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] IDX_MAX = 32'sh7FFF_FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // shadow copy of the slot pool
  logic signed [DATA_W-1:0]  pool_word [POOL_DEPTH];
  logic signed [COUNT_W-1:0] pool_count [POOL_DEPTH];

  out_item_t pending_results [$];
  out_item_t oldest;
  int        error_count = 0;
  int        stuck_cycles = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  mailbox_semaphore_table_unit #(
    .POOL_DEPTH(POOL_DEPTH),
    .SEM_BASE  (SEM_BASE),
    .SEM_LAST  (SEM_LAST)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // outcome of one request against the shadow pool, updating it
  function automatic out_item_t slot_outcome(input in_item_t req);
    out_item_t res;
    longint    mbox;
    longint    sem;
    int        k;
    res.status    = ST_OK;
    res.read_data = '0;
    mbox = longint'(signed'(req.slot_index));
    sem  = mbox + SEM_BASE;
    case (req.op)
      OP_SEND, OP_GET: begin
        if (mbox < 0 || mbox >= POOL_DEPTH) begin
          res.status = ST_RANGE;
        end else begin
          k = int'(mbox);
          if (req.op == OP_SEND) begin
            pool_word[k]  = req.write_data;
            pool_count[k] = COUNT_ONE;
          end else if (pool_count[k] == 0) begin
            res.status = ST_UNAVAIL;
          end else begin
            // any nonzero count, negative too, means full
            res.read_data = pool_word[k];
            pool_word[k]  = '0;
            pool_count[k] = '0;
          end
        end
      end
      OP_INIT, OP_TAKE, OP_GIVE: begin
        if (sem < SEM_BASE || sem > SEM_LAST || sem >= POOL_DEPTH) begin
          res.status = ST_RANGE;
        end else begin
          k = int'(sem);
          if (req.op == OP_INIT) begin
            pool_count[k] = req.init_count;
          end else if (req.op == OP_TAKE) begin
            if (pool_count[k] <= 0) res.status = ST_UNAVAIL;
            else pool_count[k] = pool_count[k] - COUNT_ONE;
          end else if (pool_count[k] != COUNT_MAX) begin
            // give saturates at the top of the count range
            pool_count[k] = pool_count[k] + COUNT_ONE;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // offer one request, wait for the handshake, record its outcome
  task automatic send_request(input in_item_t req);
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(slot_outcome(req));
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [2:0] op, input logic signed [31:0] idx,
                       input logic signed [31:0] data, input logic signed [15:0] cnt);
    in_item_t req;
    req.op         = op;
    req.slot_index = idx;
    req.write_data = data;
    req.init_count = cnt;
    send_request(req);
  endtask

  // sender pauses until every outstanding result is back
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random request, mostly on a few busy slots so state builds up
  function automatic in_item_t rand_request();
    in_item_t req;
    int       sel;
    bit       is_sem;
    sel = $urandom_range(0, 99);
    if (sel < 18) req.op = OP_SEND;
    else if (sel < 36) req.op = OP_GET;
    else if (sel < 46) req.op = OP_INIT;
    else if (sel < 66) req.op = OP_TAKE;
    else if (sel < 86) req.op = OP_GIVE;
    else if (sel < 96) req.op = (sel < 91) ? OP_SEND : OP_GET;
    else if (sel < 97) req.op = OP_SPARE5;
    else if (sel < 98) req.op = OP_SPARE6;
    else req.op = OP_SPARE7;
    is_sem = (req.op == OP_INIT || req.op == OP_TAKE || req.op == OP_GIVE);
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      if (is_sem) begin
        req.slot_index = ($urandom_range(0, 3) == 0) ? $urandom_range(120, 127)
                                                     : $urandom_range(0, 5);
      end else begin
        case ($urandom_range(0, 5))
          0:       req.slot_index = $urandom_range(248, 255);
          1:       req.slot_index = $urandom_range(126, 134);
          default: req.slot_index = $urandom_range(0, 7);
        endcase
      end
    end else if (sel < 93) begin
      case ($urandom_range(0, 5))
        0:       req.slot_index = -1;
        1:       req.slot_index = POOL_DEPTH;
        2:       req.slot_index = SEM_LAST - SEM_BASE + 1;
        3:       req.slot_index = IDX_MIN;
        4:       req.slot_index = IDX_MAX;
        default: req.slot_index = -$urandom_range(2, 300);
      endcase
    end else begin
      req.slot_index = $urandom;
    end
    req.write_data = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 55) req.init_count = 16'($urandom_range(0, 4));
    else if (sel < 65) req.init_count = 16'(-$urandom_range(0, 3));
    else if (sel < 85) req.init_count = 16'($urandom);
    else if (sel < 93) req.init_count = COUNT_MAX - 16'($urandom_range(0, 2));
    else req.init_count = 16'sh8000 + 16'($urandom_range(0, 2));
    return req;
  endfunction

  // mailbox extremes: edge slots, empty get, out-of-range indexes
  task automatic test_mailbox_edges();
    issue(OP_SEND, 0, IDX_MAX, 0);
    issue(OP_GET, 0, 0, 0);
    issue(OP_GET, 0, 0, 0);
    issue(OP_SEND, POOL_DEPTH - 1, IDX_MIN, 16'sh7FFF);
    issue(OP_GET, POOL_DEPTH - 1, 0, 0);
    issue(OP_SEND, POOL_DEPTH, 32'sh5A5A_A5A5, 0);
    issue(OP_GET, -1, 0, 0);
    issue(OP_SEND, IDX_MIN, -1, 0);
    issue(OP_GET, IDX_MAX, 0, 0);
    issue(OP_SEND, 130, 32'sh1234_5678, 0);
  endtask

  // semaphore extremes: saturation, unavailable take, range, no-op codes
  task automatic test_semaphore_edges();
    issue(OP_INIT, 0, 0, COUNT_MAX);
    issue(OP_GIVE, 0, 0, 0);
    issue(OP_TAKE, 0, 0, 0);
    issue(OP_INIT, SEM_LAST - SEM_BASE, 0, 16'sh8000);
    issue(OP_TAKE, SEM_LAST - SEM_BASE, 0, 0);
    issue(OP_GIVE, SEM_LAST - SEM_BASE, 0, 0);
    issue(OP_GET, SEM_LAST, 0, 0);
    issue(OP_TAKE, 2, 0, 0);
    issue(OP_TAKE, 2, 0, 0);
    issue(OP_INIT, SEM_LAST - SEM_BASE + 1, 0, 5);
    issue(OP_TAKE, -1, 0, 0);
    issue(OP_GIVE, IDX_MAX, 0, 0);
    issue(OP_INIT, IDX_MIN, 0, 1);
    issue(OP_SPARE5, 0, -1, -1);
    issue(OP_SPARE6, 3, -1, -1);
    issue(OP_SPARE7, -1, -1, -1);
    wait_until_drained();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    int i;
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (i = 0; i < 12; i++) send_request(rand_request());
    wait_until_drained();
    quiet = 1'b0;
  endtask

  // long random run, with stretches of no idling
  task automatic test_random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      quiet = ((i / 200) % 4 == 3);
      send_request(rand_request());
    end
    quiet = 1'b0;
    wait_until_drained();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate(input int count);
    int i;
    quiet = 1'b1;
    for (i = 0; i < count; i++) send_request(rand_request());
    wait_until_drained();
  endtask

  // receiver side: random stall bursts, or one long hold on request
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result transaction with the oldest outstanding one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (error_count < REPORT_MAX)
          $display("unexpected result: status %0d read_data %0d",
                   out_item.status, out_item.read_data);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_item.status !== oldest.status) begin
          if (error_count < REPORT_MAX)
            $display("status mismatch: expected %0d actual %0d",
                     oldest.status, out_item.status);
          error_count++;
        end
        if (out_item.read_data !== oldest.read_data) begin
          if (error_count < REPORT_MAX)
            $display("read_data mismatch: expected %0d actual %0d",
                     oldest.read_data, out_item.read_data);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // sequence of tests
  initial begin
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_word[i]  = '0;
      pool_count[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_mailbox_edges();
    test_semaphore_edges();
    test_output_backpressure();
    test_random_traffic(1550);
    test_full_rate(120);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
